/* rtl/ipv6_flow_label_marker_top_macros.svh */
// ----------------------------------------------------------------------------
// ipv6_flow_label_marker_top_macros
// Assertion macros shared by the flow label marker RTL.
// ----------------------------------------------------------------------------
`ifndef IPV6_FLOW_LABEL_MARKER_TOP_MACROS_SVH
`define IPV6_FLOW_LABEL_MARKER_TOP_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define FLM_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the following edge.
`define FLM_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* rtl/flm_pkg.sv */
// ----------------------------------------------------------------------------
// flm_pkg
// Types and constants of the flow label marker.
// ----------------------------------------------------------------------------
package flm_pkg;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [7:0] NH_TCP = 8'd6;
  localparam logic [7:0] NH_ICMP6 = 8'd58;
  localparam logic [16:0] LEN_V6_MIN = 17'd54;
  localparam logic [16:0] LEN_VLAN_MIN = 17'd58;
  localparam logic [16:0] LEN_TCP = 17'd20;
  localparam logic [15:0] ICMP_DPORT = 16'd5777;
  localparam logic [15:0] ICMP_SPORT = 16'd2345;
  localparam logic [23:0] MISS_LABEL = 24'h0FFFFF;

  typedef enum logic [2:0] {
    ST_PASS = 3'd0, ST_MISS = 3'd1, ST_MARK = 3'd2, ST_STORE = 3'd3, ST_EVICT = 3'd4
  } status_t;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE} fsm_t;

  // Operation broadcast to all cells.
  typedef enum logic [1:0] {OP_NONE, OP_TOUCH, OP_WRITE} cell_op_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] ports;
  } key_t;
endpackage

/* rtl/ipv6_flow_label_marker_top.sv */
// ----------------------------------------------------------------------------
// ipv6_flow_label_marker_top
// IPv6 flow label marker with an exact-match, exact-LRU flow table.
// ----------------------------------------------------------------------------
// Each word is handled in order: start is accepted, the row of cells compares
// the key against every entry and registers hit, free slot and victim, then
// the age update and write go back to the cells while the result appears on
// done for one cycle. busy stays high from start until done; the receiver
// cannot stall, so done marks the only cycle a result is valid.
// Age ranks are kept exact: valid entries always hold distinct ages 0..n-1.
module ipv6_flow_label_marker_top #(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] outer_ethertype,
  input  logic [15:0] inner_ethertype,
  input  logic [15:0] frame_length,
  input  logic [7:0]  next_header,
  input  logic [63:0] dest_addr_hi,
  input  logic [63:0] dest_addr_lo,
  input  logic [15:0] dest_port,
  input  logic [15:0] src_port,
  input  logic [23:0] label_bytes_in,
  input  logic [19:0] tag_value,
  output logic        done,
  output logic [23:0] label_bytes_out,
  output logic [2:0]  status
);
  import flm_pkg::*;
  `include "ipv6_flow_label_marker_top_macros.svh"
  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  logic debug_icmp;
  fsm_t state, state_next;

  // Captured word.
  logic        w_install, w_icmp, w_look;
  key_t        w_key;
  logic [23:0] w_label;
  logic [19:0] w_tag;

  // Table side.
  cell_op_t          op;
  logic [IDX_W-1:0]  target;
  logic [IDX_W:0]    touch_age;
  logic              t_hit, t_free;
  logic [IDX_W-1:0]  t_hidx, t_fidx, t_oidx;
  logic [IDX_W:0]    t_hage, t_oage;
  logic [19:0]       t_htag;

  // Classify at accept time.
  logic [16:0] flen;
  logic        v6, vlan, room_ip, is_icmp, is_tcp;
  always_comb begin
    flen    = {1'b0, frame_length};
    v6      = outer_ethertype == ETYPE_IPV6;
    vlan    = outer_ethertype == ETYPE_VLAN && inner_ethertype == ETYPE_IPV6;
    room_ip = (v6 && flen >= LEN_V6_MIN) || (vlan && flen >= LEN_VLAN_MIN);
    is_icmp = room_ip && debug_icmp && next_header == NH_ICMP6;
    is_tcp  = room_ip && !is_icmp && next_header == NH_TCP &&
              ((v6 && flen >= LEN_V6_MIN + LEN_TCP) ||
               (vlan && flen >= LEN_VLAN_MIN + LEN_TCP));
  end

  always_ff @(posedge clk) begin
    if (rst) debug_icmp <= 1'b0;
    else if (cfg_we) debug_icmp <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      w_install <= mode;
      w_icmp    <= !mode && is_icmp;
      w_look    <= mode || is_icmp || is_tcp;
      w_key.hi  <= dest_addr_hi;
      w_key.lo  <= dest_addr_lo;
      w_key.ports <= (!mode && is_icmp) ? {ICMP_DPORT, ICMP_SPORT}
                                        : {dest_port, src_port};
      w_label   <= label_bytes_in;
      w_tag     <= tag_value;
    end
  end

  // Next state.
  always_comb begin
    case (state)
      S_IDLE:   state_next = (start) ? S_SEARCH : S_IDLE;
      S_SEARCH: state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Outputs and table command.
  always_comb begin
    busy      = state != S_IDLE;
    done      = 1'b0;
    op        = OP_NONE;
    target    = t_hidx;
    touch_age = t_hage;
    label_bytes_out = w_label;
    status    = ST_PASS;
    case (state)
      S_UPDATE: begin
        done = 1'b1;
        if (w_install) begin
          label_bytes_out = '0;
          op = OP_WRITE;
          if (t_hit) begin
            status = ST_STORE;
          end else if (t_free) begin
            status    = ST_STORE;
            target    = t_fidx;
            touch_age = (IDX_W+1)'(FLOW_ENTRIES);
          end else begin
            status    = ST_EVICT;
            target    = t_oidx;
            touch_age = t_oage;
          end
        end else if (w_look) begin
          if (t_hit) begin
            op = OP_TOUCH;
            status = ST_MARK;
            label_bytes_out = {4'h0, t_htag};
          end else begin
            status = ST_MISS;
            if (w_icmp) label_bytes_out = MISS_LABEL;
          end
        end
      end
      default: ;
    endcase
  end

  flm_table #(.ENTRIES(FLOW_ENTRIES), .IDX_W(IDX_W)) u_table (
    .clk, .rst, .key(w_key), .op, .target, .touch_age, .tag_in(w_tag),
    .hit(t_hit), .hit_idx(t_hidx), .hit_age(t_hage), .hit_tag(t_htag),
    .has_free(t_free), .free_idx(t_fidx), .old_idx(t_oidx), .old_age(t_oage)
  );

  `FLM_ASSERT_IMPL(a_done_upd, clk, rst, done, state == S_UPDATE)
  `FLM_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done)
  `FLM_ASSERT_NEXT(a_search_done, clk, rst, state == S_SEARCH, done)
endmodule

/* rtl/flm_cell.sv */
// ----------------------------------------------------------------------------
// flm_cell
// One flow table entry: key compare, age keeping, and a link in the
// free-slot and oldest-entry chains.
// ----------------------------------------------------------------------------
module flm_cell #(
  parameter int IDX_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  flm_pkg::key_t     key,
  input  flm_pkg::cell_op_t op,
  input  logic              sel,        // this cell is the target
  input  logic [IDX_W:0]    touch_age,  // age of the target before touch
  input  logic [19:0]       tag_in,
  input  logic              free_in,    // a lower cell is free
  output logic              free_out,
  output logic              first_free, // this cell is the lowest free
  input  logic              old_in,     // an oldest cell lies below
  output logic              old_out,
  output logic              is_old,     // lowest cell with the top age
  input  logic [IDX_W:0]    max_age,
  output logic              hit,
  output logic [IDX_W:0]    age,
  output logic [19:0]       tag
);
  import flm_pkg::*;
  logic         valid;
  key_t         ekey;

  assign hit        = valid && ekey == key;
  assign first_free = !valid && !free_in;
  assign free_out   = free_in || !valid;
  assign is_old     = valid && age == max_age && !old_in;
  assign old_out    = old_in || (valid && age == max_age);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (op == OP_WRITE && sel) begin
      valid <= 1'b1;
      age   <= '0;
    end else if (op == OP_TOUCH && sel) begin
      age <= '0;
    end else if (op != OP_NONE && valid && age < touch_age) begin
      age <= age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_WRITE && sel) ekey <= key;
    if (op != OP_NONE && sel && op == OP_WRITE) tag <= tag_in;
  end
endmodule

/* rtl/flm_table.sv */
// ----------------------------------------------------------------------------
// flm_table
// Row of flow cells with registered hit, free and victim results.
// ----------------------------------------------------------------------------
module flm_table #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  flm_pkg::key_t     key,
  input  flm_pkg::cell_op_t op,
  input  logic [IDX_W-1:0]  target,
  input  logic [IDX_W:0]    touch_age,
  input  logic [19:0]       tag_in,
  output logic              hit,
  output logic [IDX_W-1:0]  hit_idx,
  output logic [IDX_W:0]    hit_age,
  output logic [19:0]       hit_tag,
  output logic              has_free,
  output logic [IDX_W-1:0]  free_idx,
  output logic [IDX_W-1:0]  old_idx,
  output logic [IDX_W:0]    old_age
);
  import flm_pkg::*;
  logic [ENTRIES-1:0] c_hit, c_ff, c_old;
  logic [ENTRIES:0]   fchain, ochain;
  logic [IDX_W:0]     c_age [ENTRIES];
  logic [19:0]        c_tag [ENTRIES];
  logic [IDX_W:0]     max_age;

  // A victim is only taken from a full table, where exact LRU ranks run
  // 0..ENTRIES-1, so the oldest entry always holds the top rank.
  assign max_age = (IDX_W+1)'(ENTRIES - 1);

  assign fchain[0] = 1'b0;
  assign ochain[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    flm_cell #(.IDX_W(IDX_W)) u_cell (
      .clk, .rst, .key, .op,
      .sel(target == IDX_W'(g)), .touch_age, .tag_in,
      .free_in(fchain[g]), .free_out(fchain[g+1]), .first_free(c_ff[g]),
      .old_in(ochain[g]), .old_out(ochain[g+1]), .is_old(c_old[g]),
      .max_age, .hit(c_hit[g]), .age(c_age[g]), .tag(c_tag[g])
    );
  end

  logic              hit_c;
  logic [IDX_W-1:0]  hidx_c, fidx_c, oidx_c;
  always_comb begin
    hit_c  = |c_hit;
    hidx_c = '0;
    fidx_c = '0;
    oidx_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_hit[i]) hidx_c = IDX_W'(i);
      if (c_ff[i])  fidx_c = IDX_W'(i);
      if (c_old[i]) oidx_c = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    hit      <= hit_c;
    hit_idx  <= hidx_c;
    hit_age  <= c_age[hidx_c];
    hit_tag  <= c_tag[hidx_c];
    has_free <= fchain[ENTRIES];
    free_idx <= fidx_c;
    old_idx  <= oidx_c;
    old_age  <= c_age[oidx_c];
  end
endmodule
